/* rtl/wtsf_pkg.sv */
// Package for the word tokenizer with stop word filter.
// Holds the store sizes, character codes and stop word letter codes.
// Used by the top level and by the port checker.
package wtsf_pkg;

	// Word store sizing.
	localparam int MAX_WORD    = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
	localparam int LETTER_W    = 5;
	localparam int CHAR_W      = 7;

	// ASCII bounds of letters.
	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_LO_Z = 8'h7A;

	// Output character bounds.
	localparam logic [CHAR_W-1:0] OUT_CHAR_A = 7'h61;
	localparam logic [CHAR_W-1:0] OUT_CHAR_Z = 7'h7A;

	// Letter codes used by the stop word test ('a' is zero).
	localparam logic [LETTER_W-1:0] LET_A = 5'd0;
	localparam logic [LETTER_W-1:0] LET_E = 5'd4;
	localparam logic [LETTER_W-1:0] LET_I = 5'd8;
	localparam logic [LETTER_W-1:0] LET_N = 5'd13;
	localparam logic [LETTER_W-1:0] LET_O = 5'd14;
	localparam logic [LETTER_W-1:0] LET_S = 5'd18;
	localparam logic [LETTER_W-1:0] LET_U = 5'd20;
	localparam logic [LETTER_W-1:0] LET_Y = 5'd24;

endpackage

/* rtl/wtsf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing else in the project.
module wtsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/word_tokenizer_stopword_filter_unit.sv */
// Top level of the word tokenizer with stop word filter.
// Depends on wtsf_pkg and on the generic RAM wtsf_ram.
//
// Usage:
// The input channel (in_valid, in_stall, in_char) takes one ASCII byte per
// item. The output channel (out_valid, out_stall, out_char, word_end) gives
// one lower-case letter per item, with word_end set on the last letter.
// A letter byte (either case) is folded to lower case and stored in the word
// memory; letters past 64 are dropped. It gives no result.
// Any other byte ends the word. If the word is non-empty and is not a stop
// word (a, e, y, o, u, si, no), its letters are read back from the memory.
// After the separator is accepted, state S_READ reads the first letter and
// state S_WAIT moves each letter into the output register while reading the
// next, one letter per cycle while out_stall is low. While a
// word is read out, in_stall is high. After the last letter is loaded the
// input is accepted again even while that letter waits in the output register.
// When out_stall is high the output register holds its item and the readout
// pauses. Reset empties the word and the output register; the memory itself
// needs no clearing since only entries of the current word are read.
module word_tokenizer_stopword_filter_unit
	import wtsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] out_char,
	output logic              word_end
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WAIT
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    len_q;
	logic [ADDR_W-1:0]   rd_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [LETTER_W-1:0] first_q;
	logic [LETTER_W-1:0] second_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                word_end_q;

	logic                in_acc;
	logic                is_upper;
	logic                is_lower;
	logic                is_letter;
	logic [LETTER_W-1:0] letter;
	logic                room;
	logic                stop_word;
	logic                load;
	logic                last;
	logic                wr_en;
	logic                rd_en;
	logic [LETTER_W-1:0] rd_data;

	// Classify the incoming byte and fold it to a letter code.
	always_comb begin
		is_upper = (in_char >= CHAR_UP_A) && (in_char <= CHAR_UP_Z);
		is_lower = (in_char >= CHAR_LO_A) && (in_char <= CHAR_LO_Z);
		is_letter = is_upper || is_lower;
		if (is_upper) begin
			letter = LETTER_W'(in_char - CHAR_UP_A);
		end else begin
			letter = LETTER_W'(in_char - CHAR_LO_A);
		end
	end

	// Stop word test on the first two letters, kept beside the memory.
	always_comb begin
		stop_word = 1'b0;
		if (len_q == LEN_W'(1)) begin
			stop_word = (first_q == LET_A) || (first_q == LET_E) || (first_q == LET_Y) ||
				(first_q == LET_O) || (first_q == LET_U);
		end else if (len_q == LEN_W'(2)) begin
			stop_word = ((first_q == LET_S) && (second_q == LET_I)) ||
				((first_q == LET_N) && (second_q == LET_O));
		end
	end

	// Handshake and memory control.
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign room     = (len_q < LEN_W'(MAX_WORD)) && (len_q < LEN_W'(STORE_DEPTH));
	assign wr_en    = in_acc && is_letter && room;
	assign load     = (state_q == S_WAIT) && (!out_valid_q || !out_stall);
	assign last     = ((LEN_W'(cnt_q) + LEN_W'(1)) == len_q);
	assign rd_en    = (state_q == S_READ) || (load && !last);

	wtsf_ram #(
		.WIDTH(LETTER_W),
		.DEPTH(STORE_DEPTH)
	) u_word_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(len_q[ADDR_W-1:0]),
		.wr_data(letter),
		.rd_en  (rd_en),
		.rd_addr(rd_q),
		.rd_data(rd_data)
	);

	// First two letters of the word for the stop word test, and the output letter and word_end.
	always_ff @(posedge clk) begin
		if (wr_en && (len_q == LEN_W'(0))) begin
			first_q <= letter;
		end
		if (wr_en && (len_q == LEN_W'(1))) begin
			second_q <= letter;
		end
		if (load) begin
			out_char_q <= OUT_CHAR_A + CHAR_W'(rd_data);
			word_end_q <= last;
		end
	end

	// State machine, word length, read counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A loaded letter fills the output register; an accepted one leaves it.
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_q <= rd_q + ADDR_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (is_letter) begin
							if (room) begin
								len_q <= len_q + LEN_W'(1);
							end
						end else if ((len_q != LEN_W'(0)) && !stop_word) begin
							state_q <= S_READ;
							rd_q    <= '0;
							cnt_q   <= '0;
						end else begin
							len_q <= '0;
						end
					end
				end
				S_READ: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (load) begin
						cnt_q <= cnt_q + ADDR_W'(1);
						if (last) begin
							state_q <= S_IDLE;
							len_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign word_end  = word_end_q;

endmodule

/* rtl/wtsf_checker.sv */
// Port checker for the word tokenizer with stop word filter.
// Depends on wtsf_pkg; bound to word_tokenizer_stopword_filter_unit below.
module wtsf_checker
	import wtsf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [7:0]        in_char,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAR_W-1:0] out_char,
	input logic              word_end
);

	logic letter_in;

	assign letter_in = ((in_char >= CHAR_UP_A) && (in_char <= CHAR_UP_Z)) ||
		((in_char >= CHAR_LO_A) && (in_char <= CHAR_LO_Z));

	// A stalled result item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(word_end))
		else $error("stalled result item changed");

	// A letter never starts a readout, so input stays open.
	a_letter_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && letter_in |=> !in_stall)
		else $error("letter item closed the input");

	// Every result is a lower-case letter.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= OUT_CHAR_A) && (out_char <= OUT_CHAR_Z))
		else $error("result item is not a lower-case letter");

	// A new result only comes out of a readout, during which input is held.
	a_rise_readout: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item appeared outside a readout");

endmodule

bind word_tokenizer_stopword_filter_unit wtsf_checker u_wtsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_char  (in_char),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_char (out_char),
	.word_end (word_end)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for word_tokenizer_stopword_filter_unit.
// Depends on wtsf_pkg and the unit's RTL; predicts emitted letters from the byte stream.

module testbench;
	import wtsf_pkg::*;

	// One emitted letter as seen on the output channel.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              ends;
	} letter_t;

	// One input item; typed rows carry the word they must produce.
	typedef struct {
		logic [7:0] ch;
		bit         typed;
		string      want;
	} stim_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic [7:0]        in_char   = 8'h00;
	logic              out_stall = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic [CHAR_W-1:0] out_char;
	logic              word_end;

	// Directed items: empty word, letter bounds, every stop word but "o", byte ranges.
	stim_row_t directed_rows [25] = '{
		'{8'h00, 1'b1, ""},      // separator on an empty word
		'{8'h41, 1'b0, ""},      // 'A'
		'{8'h5A, 1'b0, ""},      // 'Z'
		'{8'h61, 1'b0, ""},      // 'a'
		'{8'h7A, 1'b0, ""},      // 'z'
		'{8'h20, 1'b1, "azaz"},
		'{8'h61, 1'b0, ""},
		'{8'hFF, 1'b1, ""},      // "a" is a stop word
		'{8'h45, 1'b0, ""},
		'{8'h00, 1'b1, ""},      // "e"
		'{8'h53, 1'b0, ""},
		'{8'h69, 1'b0, ""},
		'{8'h80, 1'b1, ""},      // "si"
		'{8'h4E, 1'b0, ""},
		'{8'h6F, 1'b0, ""},
		'{8'h2E, 1'b1, ""},      // "no"
		'{8'h79, 1'b0, ""},
		'{8'h40, 1'b1, ""},      // "y", ended by the byte below 'A'
		'{8'h62, 1'b0, ""},
		'{8'h5B, 1'b1, "b"},     // byte above 'Z'
		'{8'h55, 1'b0, ""},
		'{8'h60, 1'b1, ""},      // "u", ended by the byte below 'a'
		'{8'h73, 1'b0, ""},
		'{8'h7B, 1'b1, "s"},     // byte above 'z'
		'{8'h7F, 1'b1, ""}       // separator right after a separator
	};

	string stop_words [7] = '{"a", "e", "y", "o", "u", "si", "no"};
	string near_letters = "aeinosuy";

	stim_row_t stim [$];
	letter_t   pending_letters [$];
	letter_t   word_out [$];

	// Predictor state.
	logic [LETTER_W-1:0] word_store [STORE_DEPTH];
	int                  word_len = 0;

	int accepted     = 0;
	int mismatch_cnt = 0;
	int stall_mode   = 0;
	int stall_phase  = 0;

	word_tokenizer_stopword_filter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_char  (in_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.word_end (word_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit is_letter(logic [7:0] b);
		return (b >= CHAR_UP_A && b <= CHAR_UP_Z) || (b >= CHAR_LO_A && b <= CHAR_LO_Z);
	endfunction

	function automatic bit is_stop_word();
		if (word_len == 1)
			return word_store[0] inside {LET_A, LET_E, LET_Y, LET_O, LET_U};
		if (word_len == 2)
			return (word_store[0] == LET_S && word_store[1] == LET_I) ||
			       (word_store[0] == LET_N && word_store[1] == LET_O);
		return 1'b0;
	endfunction

	// Feeds one byte to the predictor; the letters it releases land in word_out.
	function automatic void tokenize_byte(logic [7:0] b);
		letter_t l;
		word_out = {};
		if (is_letter(b)) begin
			// Letters past the word limit are dropped.
			if (word_len < MAX_WORD) begin
				if (b <= CHAR_UP_Z)
					word_store[word_len] = LETTER_W'(b - CHAR_UP_A);
				else
					word_store[word_len] = LETTER_W'(b - CHAR_LO_A);
				word_len++;
			end
			return;
		end
		if (word_len > 0 && !is_stop_word()) begin
			for (int k = 0; k < word_len; k++) begin
				l.ch   = OUT_CHAR_A + CHAR_W'(word_store[k]);
				l.ends = (k == word_len - 1);
				word_out.push_back(l);
			end
		end
		word_len = 0;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// Gives a lower-case letter a random case.
	function automatic logic [7:0] random_case(logic [7:0] lower);
		return $urandom_range(0, 1) ? lower - 8'h20 : lower;
	endfunction

	function automatic logic [7:0] random_separator();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (is_letter(b))
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic void push_byte(logic [7:0] b);
		stim_row_t row;
		row.ch    = b;
		row.typed = 1'b0;
		row.want  = "";
		stim.push_back(row);
	endfunction

	// Random part: one word longer than the store first, then mostly words with
	// separators, some stop words, some near misses, and raw noise bytes.
	task automatic build_stimulus();
		int pick;
		int len;
		string sw;
		logic [7:0] c;
		foreach (directed_rows[i])
			stim.push_back(directed_rows[i]);
		len = $urandom_range(MAX_WORD + 1, MAX_WORD + 6);
		for (int k = 0; k < len; k++)
			push_byte(random_case(CHAR_LO_A + 8'($urandom_range(0, 25))));
		push_byte(random_separator());
		while (stim.size() < 130) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				push_byte(8'($urandom_range(0, 255)));
				continue;
			end
			if (pick < 30) begin
				sw = stop_words[$urandom_range(0, 6)];
				for (int k = 0; k < sw.len(); k++)
					push_byte(random_case(sw[k]));
			end else begin
				len = $urandom_range(1, 9);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 1))
						c = near_letters[$urandom_range(0, 7)];
					else
						c = CHAR_LO_A + 8'($urandom_range(0, 25));
					push_byte(random_case(c));
				end
			end
			push_byte(random_separator());
		end
		// Close the last word.
		push_byte(8'h00);
	endtask

	// Sender: bursts of random length separated by random gaps.
	task automatic send_all();
		int burst_left;
		int gap;
		burst_left = 0;
		foreach (stim[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			in_valid <= 1'b1;
			in_char  <= stim[i].ch;
			do @(posedge clk); while (in_stall);
			burst_left--;
		end
		in_valid <= 1'b0;
	endtask

	// Receiver stall pattern, from a mode redrawn at random on the stall_phase counter.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase % 48 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= (stall_phase % 5) < 3;
			default: out_stall <= (stall_phase / 8) % 2 == 1;
		endcase
	end

	// Predicts on every accepted item and checks every accepted result.
	always @(posedge clk) begin : monitor
		letter_t got;
		letter_t want;
		if (arst_n) begin
			if (in_valid && !in_stall && accepted < stim.size()) begin
				tokenize_byte(stim[accepted].ch);
				if (stim[accepted].typed) begin
					for (int i = 0; i < stim[accepted].want.len(); i++) begin
						want.ch   = CHAR_W'(stim[accepted].want[i]);
						want.ends = (i == stim[accepted].want.len() - 1);
						pending_letters.push_back(want);
					end
				end else begin
					foreach (word_out[i])
						pending_letters.push_back(word_out[i]);
				end
				accepted++;
			end
			if (out_valid && !out_stall) begin
				got.ch   = out_char;
				got.ends = word_end;
				if (pending_letters.size() == 0) begin
					note_mismatch($sformatf("unexpected item: out_char=%h word_end=%b",
						got.ch, got.ends));
				end else begin
					want = pending_letters.pop_front();
					if (got.ch !== want.ch || got.ends !== want.ends)
						note_mismatch($sformatf(
							"mismatch: expected out_char=%h word_end=%b, got %h %b",
							want.ch, want.ends, got.ch, got.ends));
				end
			end
		end
	end

	initial begin
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_all();
		// Let the monitor take in the last accepted item first.
		@(posedge clk);
		while (pending_letters.size() != 0)
			@(posedge clk);
		// Keep watching the output for unexpected extra items.
		repeat (200) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("word_tokenizer_stopword_filter_unit regression: pass");
		else
			$display("word_tokenizer_stopword_filter_unit regression: fail");
		$finish;
	end

	initial begin : watchdog
		#(10_000_000);
		$display("word_tokenizer_stopword_filter_unit regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/wtsf_pkg.sv
rtl/wtsf_ram.sv
rtl/word_tokenizer_stopword_filter_unit.sv
rtl/wtsf_checker.sv
tb/sv/testbench.sv
